FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// condition in one cycle implies a condition in the next
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   `ASSERT_PROP(label, clk, rst, (ante) |=> (cons))

`endif

FILE: rtl/dacs_pkg.sv
// shared types, constants and helpers of the dual converter scanner
package dacs_pkg;

   localparam int CHANNEL_COUNT = 16;

   localparam logic [15:0] CMD_BASE = 16'h8310;

   localparam logic [19:0] MOTOR_GAIN_RESET  = 20'd354248;
   localparam logic [18:0] MOTOR_ZERO_RESET  = 19'd163840;
   localparam logic [19:0] SYSTEM_GAIN_RESET = 20'd327680;
   localparam logic [18:0] SYSTEM_ZERO_RESET = 19'd32768;

   localparam logic [1:0] REG_MOTOR_GAIN  = 2'd0;
   localparam logic [1:0] REG_MOTOR_ZERO  = 2'd1;
   localparam logic [1:0] REG_SYSTEM_GAIN = 2'd2;
   localparam logic [1:0] REG_SYSTEM_ZERO = 2'd3;

   localparam logic ACTION_SCAN  = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   localparam logic [2:0] KIND_MOTOR    = 3'd0;
   localparam logic [2:0] KIND_DISTANCE = 3'd1;
   localparam logic [2:0] KIND_SYSTEM   = 3'd2;
   localparam logic [2:0] KIND_IO       = 3'd3;
   localparam logic [2:0] KIND_GENERAL  = 3'd4;

   localparam logic [3:0] SYSTEM_CHANNEL = 4'd12;

   typedef struct packed {
      logic [19:0] motor_gain;
      logic [18:0] motor_zero;
      logic [19:0] system_gain;
      logic [18:0] system_zero;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   // sample code to q16 volts, 5 V full scale over 4096 codes
   function automatic logic [18:0] volts_of(input logic [11:0] s);
      volts_of = 19'(s) * 19'd80;
   endfunction

endpackage

FILE: rtl/dacs_csr.sv
// apb configuration registers for gains and zero points
module dacs_csr
   import dacs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (csr_paddr[3:2])
            REG_MOTOR_GAIN:  cfg_in.motor_gain  = csr_pwdata[19:0];
            REG_MOTOR_ZERO:  cfg_in.motor_zero  = csr_pwdata[18:0];
            REG_SYSTEM_GAIN: cfg_in.system_gain = csr_pwdata[19:0];
            REG_SYSTEM_ZERO: cfg_in.system_zero = csr_pwdata[18:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_MOTOR_GAIN:  csr_prdata = 32'(cfg_ff.motor_gain);
         REG_MOTOR_ZERO:  csr_prdata = 32'(cfg_ff.motor_zero);
         REG_SYSTEM_GAIN: csr_prdata = 32'(cfg_ff.system_gain);
         REG_SYSTEM_ZERO: csr_prdata = 32'(cfg_ff.system_zero);
         default:         csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.motor_gain  <= MOTOR_GAIN_RESET;
         cfg_ff.motor_zero  <= MOTOR_ZERO_RESET;
         cfg_ff.system_gain <= SYSTEM_GAIN_RESET;
         cfg_ff.system_zero <= SYSTEM_ZERO_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/dacs_ctrl.sv
// controller state machine sequencing accept, multiply and finish
module dacs_ctrl
   import dacs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

`include "assert_macros.svh"

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_NEXT(a_accept_to_mul, clock, reset, req_tvalid && req_tready, state_ff == ST_MUL)
   `ASSERT_NEXT(a_mul_to_fin, clock, reset, state_ff == ST_MUL, state_ff == ST_FIN)

endmodule

FILE: rtl/dacs_datapath.sv
// sample tables, channel counter, current scaling and output register
module dacs_datapath
   import dacs_pkg::*;
#(
   parameter int CHANNELS = CHANNEL_COUNT
)(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  cfg_type            cfg,
   input  logic               action,
   input  logic [15:0]        reply_first,
   input  logic [15:0]        reply_second,
   input  logic [2:0]         query_kind,
   input  logic [3:0]         query_index,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [15:0]        command_word,
   output logic signed [20:0] scaled_value,
   output logic               index_error
);

`include "assert_macros.svh"

   localparam int AW = $clog2(CHANNELS);

   logic [11:0] first_ff  [CHANNELS];
   logic [11:0] second_ff [CHANNELS];
   logic signed [20:0] motor_ff [4];

   logic [AW-1:0] counter_ff;
   logic [AW-1:0] counter_in;

   logic        action_ff;
   logic [15:0] reply0_ff;
   logic [2:0]  kind_ff;
   logic [3:0]  idx_ff;

   logic signed [40:0] product_ff;
   logic signed [40:0] product_in;
   logic signed [20:0] value_ff;
   logic signed [20:0] value_in;
   logic               err_ff;
   logic               err_in;
   logic               use_product_ff;
   logic               use_product_in;

   logic               rsp_valid_ff;
   logic [15:0]        rsp_cmd_ff;
   logic signed [20:0] rsp_value_ff;
   logic               rsp_err_ff;

   logic [AW-1:0]      first_addr;
   logic [AW-1:0]      second_addr;
   logic [11:0]        first_sample;
   logic [11:0]        second_sample;
   logic [11:0]        mul_sample;
   logic [18:0]        mul_zero;
   logic [19:0]        mul_gain;
   logic signed [19:0] diff;
   logic signed [20:0] gain_s;

   logic               neg;
   logic [40:0]        mag;
   logic [40:0]        mag_rnd;
   logic [24:0]        rnd;
   logic signed [20:0] rounded;
   logic [3:0]         a0;

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign counter_in = (counter_ff == AW'(CHANNELS - 1)) ? '0 : counter_ff + 1'b1;

   // table read addresses for a query
   always_comb begin
      case (kind_ff)
         KIND_SYSTEM: first_addr = AW'(SYSTEM_CHANNEL);
         KIND_IO:     first_addr = AW'(idx_ff);
         default:     first_addr = AW'(SYSTEM_CHANNEL + idx_ff);
      endcase
      second_addr = (kind_ff == KIND_GENERAL) ? AW'(4'd5 + idx_ff) : AW'(idx_ff);
   end

   assign first_sample  = first_ff[first_addr];
   assign second_sample = second_ff[second_addr];

   // current scaling operands
   always_comb begin
      if (action_ff == ACTION_SCAN) begin
         mul_sample = reply0_ff[11:0];
         mul_zero   = cfg.motor_zero;
         mul_gain   = cfg.motor_gain;
      end else begin
         mul_sample = first_sample;
         mul_zero   = cfg.system_zero;
         mul_gain   = cfg.system_gain;
      end
      diff       = signed'({1'b0, volts_of(mul_sample)}) - signed'({1'b0, mul_zero});
      gain_s     = signed'({1'b0, mul_gain});
      product_in = diff * gain_s;
   end

   // query answer selection
   always_comb begin
      value_in       = '0;
      err_in         = 1'b0;
      use_product_in = 1'b0;
      if (action_ff == ACTION_QUERY) begin
         case (kind_ff)
            KIND_MOTOR: begin
               if (idx_ff <= 4'd3) value_in = motor_ff[idx_ff[1:0]];
               else err_in = 1'b1;
            end
            KIND_DISTANCE: value_in = signed'(21'(volts_of(second_sample)));
            KIND_SYSTEM:   use_product_in = 1'b1;
            KIND_IO:       value_in = signed'({1'b0, volts_of(first_sample), 1'b0});
            KIND_GENERAL: begin
               if (idx_ff inside {[4'd1:4'd3]}) begin
                  value_in = signed'(21'(volts_of(first_sample)));
               end else if (idx_ff inside {[4'd4:4'd10]}) begin
                  value_in = signed'(21'(volts_of(second_sample)));
               end else begin
                  err_in = 1'b1;
               end
            end
            default: err_in = 1'b1;
         endcase
      end
   end

   // round half away from zero, then saturate
   always_comb begin
      neg     = product_ff[40];
      mag     = neg ? 41'(-product_ff) : 41'(product_ff);
      mag_rnd = mag + 41'd32768;
      rnd     = mag_rnd[40:16];
      if (!neg) begin
         rounded = (rnd > 25'd1048575) ? 21'sd1048575 : signed'(rnd[20:0]);
      end else begin
         rounded = (rnd > 25'd1048576) ? -21'sd1048576 : signed'(21'(-rnd));
      end
   end

   assign a0 = reply0_ff[15:12];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= action;
         reply0_ff <= reply_first;
         kind_ff   <= query_kind;
         idx_ff    <= query_index;
      end
      if (cmd.mul) begin
         product_ff     <= product_in;
         value_ff       <= value_in;
         err_ff         <= err_in;
         use_product_ff <= use_product_in;
      end
      if (cmd.finish) begin
         rsp_cmd_ff   <= CMD_BASE | (16'(counter_ff) << 10);
         rsp_value_ff <= use_product_ff ? rounded : value_ff;
         rsp_err_ff   <= err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            first_ff[i]  <= '0;
            second_ff[i] <= '0;
         end
         for (int i = 0; i < 4; i++) begin
            motor_ff[i] <= '0;
         end
      end else begin
         if (cmd.load && action == ACTION_SCAN) begin
            first_ff[AW'(reply_first[15:12])]   <= reply_first[11:0];
            second_ff[AW'(reply_second[15:12])] <= reply_second[11:0];
            counter_ff <= counter_in;
         end
         if (cmd.finish && action_ff == ACTION_SCAN && (a0 inside {[4'd8:4'd11]})) begin
            motor_ff[a0[1:0]] <= rounded;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign command_word = rsp_cmd_ff;
   assign scaled_value = rsp_value_ff;
   assign index_error  = rsp_err_ff;

   `ASSERT_NEXT(a_counter_moves_on_load, clock, reset, !cmd.load, $stable(counter_ff))
   `ASSERT_PROP(a_error_gives_zero, clock, reset, (rsp_valid_ff && rsp_err_ff) |-> (rsp_value_ff == 21'sd0))

endmodule

FILE: rtl/dual_adc_channel_scan_and_scale.sv
// top level of the dual converter round robin scanner with q16 scaling
//
// req channel: one beat is a scan step (tuser 0) carrying both converter
// reply words, or a query (tuser 1) for one scaled value.
// rsp channel: one beat per request with the next command word, the
// signed q16 answer and the index error flag in tuser.
// csr port: apb writes of motor and system gain and zero registers at
// byte addresses 0, 4, 8 and 12; reads return the register value.
// sequencing: the response is registered through the accept, multiply and
// round steps of the controller around the single scaling multiplier; a
// new request beat is taken only after the previous one leaves the round step.
// a finished response waits in the output register; while the receiver
// stalls the block still takes the next request and holds its result in
// the round step until the output register frees.
// reset: channel counter, sample tables and motor currents clear to zero,
// registers return to their defaults, no response is pending.
module dual_adc_channel_scan_and_scale
   import dacs_pkg::*;
#(
   parameter int CHANNELS = CHANNEL_COUNT
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // reply_first, reply_second, query_kind, query_index, zero pad
   input  logic [39:0] req_tdata,
   // action
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // command_word, scaled_value, zero pad
   output logic [39:0] rsp_tdata,
   // index_error
   output logic        rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type            cfg;
   cmd_type            cmd;
   status_type         status;
   logic [15:0]        command_word;
   logic signed [20:0] scaled_value;

   dacs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dacs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dacs_datapath #(
      .CHANNELS (CHANNELS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .cfg          (cfg),
      .action       (req_tuser),
      .reply_first  (req_tdata[15:0]),
      .reply_second (req_tdata[31:16]),
      .query_kind   (req_tdata[34:32]),
      .query_index  (req_tdata[38:35]),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .command_word (command_word),
      .scaled_value (scaled_value),
      .index_error  (rsp_tuser)
   );

   assign rsp_tdata = {3'b000, scaled_value, command_word};

endmodule
